// ----- hdl/mps_pkg.sv -----
// Shared types and codes for the depth-first maze path search block.
// Used by the top level; no dependencies.
package mps_pkg;

    // Grid coordinate and scan direction
    typedef logic [2:0] t_coord;
    typedef logic [2:0] t_dir;

    // Scan directions in the order they are tried; DIR_END means all are spent
    localparam t_dir DIR_DOWN  = 3'd1;
    localparam t_dir DIR_RIGHT = 3'd2;
    localparam t_dir DIR_LEFT  = 3'd3;
    localparam t_dir DIR_UP    = 3'd4;
    localparam t_dir DIR_END   = 3'd5;

    // Cell marks held in the mark memory
    typedef logic [1:0] t_mark;
    localparam t_mark MARK_OPEN = 2'd0;
    localparam t_mark MARK_WALL = 2'd1;
    localparam t_mark MARK_PATH = 2'd2;
    localparam t_mark MARK_DEAD = 2'd3;

    // One path stack entry: cell and the direction it was entered from
    typedef struct packed {
        t_coord row;
        t_coord col;
        t_dir   dir;
    } t_stack_entry;

    // Configuration register indexes
    localparam logic [1:0] REG_START_ROW = 2'd0;
    localparam logic [1:0] REG_START_COL = 2'd1;
    localparam logic [1:0] REG_EXIT_ROW  = 2'd2;
    localparam logic [1:0] REG_EXIT_COL  = 2'd3;

    // Search sequencer states, one-hot
    typedef enum logic [8:0] {
        S_LOAD   = 9'b000000001,
        S_INIT   = 9'b000000010,
        S_CHECK  = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_TEST   = 9'b000010000,
        S_POP    = 9'b000100000,
        S_ERD    = 9'b001000000,
        S_EOUT   = 9'b010000000,
        S_NOEXIT = 9'b100000000
    } t_state;

endpackage

// ----- hdl/mps_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read word; hold it while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/maze_path_search_dfs.sv -----
// Depth-first maze path search: grid load, stack-based search, path readout.
// Depends on mps_pkg and mps_ram (mark memory and path stack memory).
// Load: each accepted word in the grid is stored; a word with tlast starts the search.
// Search: push the start, skip off-grid directions, probe neighbour marks (SCAN, TEST),
// backtrack by a stack read (SCAN, POP), check for the exit after each push or pop; the
// readout reads each path word (ERD, EOUT) or sends the no-exit word; m_tready stalls it.
// Reset: synchronous active-low clears control and config; memories are not cleared.
module maze_path_search_dfs #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] cell_row, [5:3] cell_col, [6] is_wall, [7] zero
    input  logic        s_tlast,   // start_search
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] path_row, [5:3] path_col, [7:6] zero
    output logic        m_tuser,   // found
    output logic        m_tlast,   // last
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [3:0] ROWS_L = 4'(ROWS);
    localparam logic [3:0] COLS_L = 4'(COLS);
    localparam int SW    = $bits(mps_pkg::t_stack_entry);

    function automatic logic [AW-1:0] cell_addr(input mps_pkg::t_coord r,
                                                input mps_pkg::t_coord c);
        return AW'(int'(r) * COLS + int'(c));
    endfunction

    // Configuration registers
    mps_pkg::t_coord r_start_row, r_start_col, r_exit_row, r_exit_col;

    // Search state
    mps_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    mps_pkg::t_dir   r_nd, n_nd;
    mps_pkg::t_coord r_row, n_row, r_col, n_col;
    mps_pkg::t_dir   r_dir, n_dir;
    mps_pkg::t_coord r_nb_row, n_nb_row, r_nb_col, n_nb_col;
    logic [AW-1:0]   r_eidx, n_eidx;

    // Output register
    logic            r_m_tvalid, n_m_tvalid;
    mps_pkg::t_coord r_o_row, n_o_row, r_o_col, n_o_col;
    logic            r_o_found, n_o_found, r_o_last, n_o_last;

    // Memory ports
    logic                  mark_we, mark_re;
    logic [AW-1:0]         mark_waddr, mark_raddr;
    mps_pkg::t_mark        mark_wdata, mark_rdata;
    logic                  stk_we, stk_re;
    logic [AW-1:0]         stk_waddr, stk_raddr;
    mps_pkg::t_stack_entry stk_wdata, stk_rdata;

    logic            in_acc, out_free, cfg_wr;
    logic            nb_ok;
    mps_pkg::t_coord nb_row, nb_col;
    logic            in_row_ok, in_col_ok;

    mps_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_marks (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_re    (mark_re),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

    mps_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // Handshakes
    assign s_tready = (r_state == mps_pkg::S_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !r_m_tvalid || m_tready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    assign in_row_ok = {1'b0, s_tdata[2:0]} < ROWS_L;
    assign in_col_ok = {1'b0, s_tdata[5:3]} < COLS_L;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row <= 3'd1;
            r_start_col <= 3'd1;
            r_exit_row  <= 3'd6;
            r_exit_col  <= 3'd6;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                mps_pkg::REG_START_ROW: r_start_row <= pwdata[2:0];
                mps_pkg::REG_START_COL: r_start_col <= pwdata[2:0];
                mps_pkg::REG_EXIT_ROW:  r_exit_row  <= pwdata[2:0];
                mps_pkg::REG_EXIT_COL:  r_exit_col  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[3:2])
            mps_pkg::REG_START_ROW: prdata = {29'd0, r_start_row};
            mps_pkg::REG_START_COL: prdata = {29'd0, r_start_col};
            mps_pkg::REG_EXIT_ROW:  prdata = {29'd0, r_exit_row};
            mps_pkg::REG_EXIT_COL:  prdata = {29'd0, r_exit_col};
            default:                prdata = 32'd0;
        endcase
    end

    // Neighbour of the top cell in the current scan direction
    always_comb begin
        nb_row = r_row;
        nb_col = r_col;
        nb_ok  = 1'b0;
        unique case (r_nd)
            mps_pkg::DIR_DOWN: begin
                nb_row = r_row + 3'd1;
                nb_ok  = ({1'b0, r_row} + 4'd1) < ROWS_L;
            end
            mps_pkg::DIR_RIGHT: begin
                nb_col = r_col + 3'd1;
                nb_ok  = ({1'b0, r_col} + 4'd1) < COLS_L;
            end
            mps_pkg::DIR_LEFT: begin
                nb_col = r_col - 3'd1;
                nb_ok  = (r_col != 3'd0);
            end
            mps_pkg::DIR_UP: begin
                nb_row = r_row - 3'd1;
                nb_ok  = (r_row != 3'd0);
            end
            default: nb_ok = 1'b0;
        endcase
    end

    // Search sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_nd       = r_nd;
        n_row      = r_row;
        n_col      = r_col;
        n_dir      = r_dir;
        n_nb_row   = r_nb_row;
        n_nb_col   = r_nb_col;
        n_eidx     = r_eidx;
        n_m_tvalid = r_m_tvalid && !m_tready;
        n_o_row    = r_o_row;
        n_o_col    = r_o_col;
        n_o_found  = r_o_found;
        n_o_last   = r_o_last;

        mark_we    = 1'b0;
        mark_waddr = cell_addr(r_row, r_col);
        mark_wdata = mps_pkg::MARK_PATH;
        mark_re    = 1'b0;
        mark_raddr = cell_addr(nb_row, nb_col);
        stk_we     = 1'b0;
        stk_waddr  = r_count[AW-1:0];
        stk_wdata  = '{row: nb_row, col: nb_col, dir: r_nd};
        stk_re     = 1'b0;
        stk_raddr  = r_eidx;

        unique case (r_state)
            mps_pkg::S_LOAD: begin
                // store the loaded cell; tlast starts the search
                if (in_acc) begin
                    mark_we    = in_row_ok && in_col_ok;
                    mark_waddr = cell_addr(s_tdata[2:0], s_tdata[5:3]);
                    mark_wdata = {1'b0, s_tdata[6]};
                    if (s_tlast) begin
                        n_state = mps_pkg::S_INIT;
                    end
                end
            end
            mps_pkg::S_INIT: begin
                // push the start cell whatever its mark; a start off the grid gives no exit
                n_count = '0;
                if (({1'b0, r_start_row} < ROWS_L) && ({1'b0, r_start_col} < COLS_L)) begin
                    mark_we    = 1'b1;
                    mark_waddr = cell_addr(r_start_row, r_start_col);
                    mark_wdata = mps_pkg::MARK_PATH;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = '{row: r_start_row, col: r_start_col, dir: mps_pkg::DIR_DOWN};
                    n_count    = CW'(1);
                    n_row      = r_start_row;
                    n_col      = r_start_col;
                    n_dir      = mps_pkg::DIR_DOWN;
                    n_nd       = mps_pkg::DIR_DOWN;
                    n_state    = mps_pkg::S_CHECK;
                end else begin
                    n_state = mps_pkg::S_NOEXIT;
                end
            end
            mps_pkg::S_CHECK: begin
                // stop at the exit and read the path out from the top
                if (r_row == r_exit_row && r_col == r_exit_col) begin
                    n_eidx  = r_count[AW-1:0] - AW'(1);
                    n_state = mps_pkg::S_ERD;
                end else begin
                    n_state = mps_pkg::S_SCAN;
                end
            end
            mps_pkg::S_SCAN: begin
                if (r_nd == mps_pkg::DIR_END) begin
                    // backtrack: mark the top dead and drop it
                    mark_we    = 1'b1;
                    mark_wdata = mps_pkg::MARK_DEAD;
                    n_count    = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_state = mps_pkg::S_NOEXIT;
                    end else begin
                        n_nd = (r_dir < mps_pkg::DIR_DOWN || r_dir > mps_pkg::DIR_UP)
                             ? mps_pkg::DIR_DOWN : r_dir;
                        stk_re    = 1'b1;
                        stk_raddr = r_count[AW-1:0] - AW'(2);
                        n_state   = mps_pkg::S_POP;
                    end
                end else if (nb_ok) begin
                    // probe the neighbour's mark
                    mark_re  = 1'b1;
                    n_nb_row = nb_row;
                    n_nb_col = nb_col;
                    n_state  = mps_pkg::S_TEST;
                end else begin
                    n_nd = r_nd + 3'd1;
                end
            end
            mps_pkg::S_TEST: begin
                if (mark_rdata == mps_pkg::MARK_OPEN) begin
                    // push the open neighbour
                    mark_we    = 1'b1;
                    mark_waddr = cell_addr(r_nb_row, r_nb_col);
                    mark_wdata = mps_pkg::MARK_PATH;
                    stk_we     = 1'b1;
                    stk_wdata  = '{row: r_nb_row, col: r_nb_col, dir: r_nd};
                    n_count    = r_count + CW'(1);
                    n_row      = r_nb_row;
                    n_col      = r_nb_col;
                    n_dir      = r_nd;
                    n_nd       = mps_pkg::DIR_DOWN;
                    n_state    = mps_pkg::S_CHECK;
                end else begin
                    n_nd    = r_nd + 3'd1;
                    n_state = mps_pkg::S_SCAN;
                end
            end
            mps_pkg::S_POP: begin
                // take the new top from the stack word
                n_row   = stk_rdata.row;
                n_col   = stk_rdata.col;
                n_dir   = stk_rdata.dir;
                n_state = mps_pkg::S_CHECK;
            end
            mps_pkg::S_ERD: begin
                stk_re  = 1'b1;
                n_state = mps_pkg::S_EOUT;
            end
            mps_pkg::S_EOUT: begin
                // hand one path cell to the output register
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_o_row    = stk_rdata.row;
                    n_o_col    = stk_rdata.col;
                    n_o_found  = 1'b1;
                    n_o_last   = (r_eidx == '0);
                    if (r_eidx == '0) begin
                        n_state = mps_pkg::S_LOAD;
                    end else begin
                        n_eidx  = r_eidx - AW'(1);
                        n_state = mps_pkg::S_ERD;
                    end
                end
            end
            mps_pkg::S_NOEXIT: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_o_row    = '0;
                    n_o_col    = '0;
                    n_o_found  = 1'b0;
                    n_o_last   = 1'b1;
                    n_state    = mps_pkg::S_LOAD;
                end
            end
            default: n_state = mps_pkg::S_LOAD;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mps_pkg::S_LOAD;
            r_count    <= '0;
            r_nd       <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_nd       <= n_nd;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_col     <= n_col;
        r_dir     <= n_dir;
        r_nb_row  <= n_nb_row;
        r_nb_col  <= n_nb_col;
        r_eidx    <= n_eidx;
        r_o_row   <= n_o_row;
        r_o_col   <= n_o_col;
        r_o_found <= n_o_found;
        r_o_last  <= n_o_last;
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {2'b00, r_o_col, r_o_row};
    assign m_tuser  = r_o_found;
    assign m_tlast  = r_o_last;

endmodule

// ----- dv/maze_path_search_dfs_tb.sv -----
`timescale 1ns / 1ps
// Testbench for maze_path_search_dfs: loads grid cells over the input stream, runs searches
// and checks every path word against an in-bench depth-first solver. Depends on mps_pkg.
module maze_path_search_dfs_tb;

    localparam int ROWS        = 8;
    localparam int COLS        = 8;
    localparam int RANDOM_CELLS = 50;
    localparam int DRAIN_HOLD  = 16;
    localparam int STALL_LIMIT = 4000;

    // One expected path word
    typedef struct {
        mps_pkg::t_coord row;
        mps_pkg::t_coord col;
        logic            found;
        logic            last;
    } t_path_cell;

    // Solver copy of the block plus the queue of path words still owed
    class maze_path_checker;
        mps_pkg::t_coord       start_r = 3'd1;
        mps_pkg::t_coord       start_c = 3'd1;
        mps_pkg::t_coord       exit_r  = 3'd6;
        mps_pkg::t_coord       exit_c  = 3'd6;
        mps_pkg::t_mark        marks [ROWS*COLS];
        mps_pkg::t_stack_entry trail [ROWS*COLS];
        int                    trail_len;
        t_path_cell            expected_path [$];
        int                    errors;

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endfunction

        function void set_reg(logic [1:0] idx, mps_pkg::t_coord val);
            case (idx)
                mps_pkg::REG_START_ROW: start_r = val;
                mps_pkg::REG_START_COL: start_c = val;
                mps_pkg::REG_EXIT_ROW:  exit_r  = val;
                default:                exit_c  = val;
            endcase
        endfunction

        function void push_trail(mps_pkg::t_coord r, mps_pkg::t_coord c, mps_pkg::t_dir d);
            trail[trail_len] = '{row: r, col: c, dir: d};
            trail_len++;
            marks[r*COLS + c] = mps_pkg::MARK_PATH;
        endfunction

        // Walk depth first from start to exit; the trail holds the path on success
        function bit solve_maze();
            mps_pkg::t_stack_entry top;
            mps_pkg::t_dir         resume;
            int                    nr;
            int                    nc;
            bit                    moved;
            trail_len = 0;
            if (start_r >= ROWS || start_c >= COLS) return 1'b0;
            push_trail(start_r, start_c, mps_pkg::DIR_DOWN);
            resume = mps_pkg::DIR_DOWN;
            forever begin
                top = trail[trail_len-1];
                if (top.row == exit_r && top.col == exit_c) return 1'b1;
                moved = 1'b0;
                for (int d = resume; d < mps_pkg::DIR_END && !moved; d++) begin
                    nr = top.row;
                    nc = top.col;
                    case (d)
                        mps_pkg::DIR_DOWN:  nr++;
                        mps_pkg::DIR_RIGHT: nc++;
                        mps_pkg::DIR_LEFT:  nc--;
                        default:            nr--;
                    endcase
                    if (nr >= 0 && nc >= 0 && nr < ROWS && nc < COLS &&
                            marks[nr*COLS + nc] == mps_pkg::MARK_OPEN) begin
                        push_trail(mps_pkg::t_coord'(nr), mps_pkg::t_coord'(nc),
                                   mps_pkg::t_dir'(d));
                        moved = 1'b1;
                    end
                end
                // Backtrack: mark dead, resume the parent at the entry direction
                if (moved) begin
                    resume = mps_pkg::DIR_DOWN;
                end else begin
                    trail_len--;
                    marks[top.row*COLS + top.col] = mps_pkg::MARK_DEAD;
                    if (trail_len == 0) return 1'b0;
                    resume = top.dir;
                end
            end
        endfunction

        // Store an accepted cell word; a search word queues the path, exit first
        function void take_cell(mps_pkg::t_coord r, mps_pkg::t_coord c, logic wall, logic go);
            if (r < ROWS && c < COLS)
                marks[r*COLS + c] = wall ? mps_pkg::MARK_WALL : mps_pkg::MARK_OPEN;
            if (!go) return;
            if (!solve_maze()) begin
                expected_path.push_back('{row: 3'd0, col: 3'd0, found: 1'b0, last: 1'b1});
            end else begin
                for (int k = trail_len - 1; k >= 0; k--)
                    expected_path.push_back('{row: trail[k].row, col: trail[k].col,
                                              found: 1'b1, last: (k == 0)});
            end
        endfunction

        function void check_path_cell(mps_pkg::t_coord r, mps_pkg::t_coord c, logic found,
                                      logic last);
            t_path_cell want;
            if (expected_path.size() == 0) begin
                report($sformatf("unexpected word row=%0d col=%0d found=%0b last=%0b",
                                 r, c, found, last));
                return;
            end
            want = expected_path.pop_front();
            if (r !== want.row || c !== want.col || found !== want.found || last !== want.last)
                report($sformatf("got row=%0d col=%0d found=%0b last=%0b, want %0d %0d %0b %0b",
                                 r, c, found, last, want.row, want.col, want.found, want.last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    maze_path_checker sb = new();
    int send_gap_pct   = 8;
    int recv_stall_pct = 66;
    int random_items;
    int quiet_cycles;

    maze_path_search_dfs #(.ROWS(ROWS), .COLS(COLS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stall the path stream at random
    always @(posedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Check each accepted path word
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_path_cell(m_tdata[2:0], m_tdata[5:3], m_tuser, m_tlast);
    end

    // Abort when nothing moves on any port for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Send one cell word, with an optional gap before it
    task automatic send_cell(input int r, input int c, input bit wall, input bit go);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, wall, mps_pkg::t_coord'(c), mps_pkg::t_coord'(r)};
        s_tlast  <= go;
        do @(posedge i_clk); while (!s_tready);
        sb.take_cell(mps_pkg::t_coord'(r), mps_pkg::t_coord'(c), wall, go);
    endtask

    // Write one register; upper data bits carry noise
    task automatic write_reg(input logic [1:0] idx, input mps_pkg::t_coord val);
        logic [31:0] word;
        word      = $urandom;
        word[2:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Hold the input until every path word is out, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_path.size() != 0) @(posedge i_clk);
        repeat (DRAIN_HOLD) @(posedge i_clk);
    endtask

    function automatic mps_pkg::t_coord pick_coord();
        if ($urandom_range(2) == 0) return $urandom_range(1) ? 3'd7 : 3'd0;
        return mps_pkg::t_coord'($urandom_range(7));
    endfunction

    // Maybe move start and exit, reopen part of the used grid, sprinkle walls, then search
    task automatic run_random_maze();
        int used [$];
        int n;
        int k;
        int spot;
        if ($urandom_range(2) == 0) begin
            wait_drained();
            if ($urandom_range(1)) write_reg(mps_pkg::REG_START_ROW, pick_coord());
            if ($urandom_range(1)) write_reg(mps_pkg::REG_START_COL, pick_coord());
            if ($urandom_range(1)) write_reg(mps_pkg::REG_EXIT_ROW, pick_coord());
            if ($urandom_range(1)) write_reg(mps_pkg::REG_EXIT_COL, pick_coord());
        end
        for (int i = 0; i < ROWS*COLS; i++)
            if (sb.marks[i] == mps_pkg::MARK_PATH || sb.marks[i] == mps_pkg::MARK_DEAD)
                used.push_back(i);
        // now and then search on stale marks alone
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 20);
        for (int i = 0; i < n; i++) begin
            if (used.size() > 0 && $urandom_range(3) != 0) begin
                k    = $urandom_range(used.size() - 1);
                spot = used[k];
                used.delete(k);
            end else begin
                spot = $urandom_range(ROWS*COLS - 1);
            end
            send_cell(spot / COLS, spot % COLS, $urandom_range(99) < 22, 1'b0);
        end
        if ($urandom_range(3) != 0)
            send_cell(sb.exit_r, sb.exit_c, 1'b0, 1'b1);
        else
            send_cell($urandom_range(7), $urandom_range(7), 1'($urandom_range(1)), 1'b1);
        random_items += n + 1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Start is a wall and equals the exit: one path word
        write_reg(mps_pkg::REG_START_ROW, 3'd3);
        write_reg(mps_pkg::REG_START_COL, 3'd4);
        write_reg(mps_pkg::REG_EXIT_ROW, 3'd3);
        write_reg(mps_pkg::REG_EXIT_COL, 3'd4);
        send_cell(3, 4, 1'b1, 1'b1);
        wait_drained();

        // Start equals exit at the far corner, never loaded
        write_reg(mps_pkg::REG_START_ROW, 3'd7);
        write_reg(mps_pkg::REG_START_COL, 3'd7);
        write_reg(mps_pkg::REG_EXIT_ROW, 3'd7);
        write_reg(mps_pkg::REG_EXIT_COL, 3'd7);
        send_cell(0, 0, 1'b0, 1'b1);
        wait_drained();

        // Load the whole grid corner to corner, search on the last word
        write_reg(mps_pkg::REG_START_ROW, 3'd0);
        write_reg(mps_pkg::REG_START_COL, 3'd0);
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                send_cell(r, c,
                          ((r == 0 && c == 0) || (r == 7 && c == 7)) ? 1'b0
                                                                     : ($urandom_range(99) < 25),
                          (r == 7 && c == 7));

        // Marks stay from the last search
        send_cell(7, 7, 1'b0, 1'b1);
        wait_drained();

        // Start boxed in by walls and the grid edge: stack runs empty
        write_reg(mps_pkg::REG_START_ROW, 3'd7);
        write_reg(mps_pkg::REG_START_COL, 3'd0);
        write_reg(mps_pkg::REG_EXIT_ROW, 3'd0);
        write_reg(mps_pkg::REG_EXIT_COL, 3'd7);
        send_cell(6, 0, 1'b1, 1'b0);
        send_cell(7, 1, 1'b1, 1'b0);
        send_cell(7, 0, 1'b0, 1'b1);
        wait_drained();

        // Random mazes over three idle profiles
        while (random_items < RANDOM_CELLS) begin
            if (random_items < RANDOM_CELLS / 3) begin
                send_gap_pct   = 8;
                recv_stall_pct = 66;
            end else if (random_items < 2 * RANDOM_CELLS / 3) begin
                send_gap_pct   = 66;
                recv_stall_pct = 8;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            run_random_maze();
        end

        wait_drained();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
